[rtl/pswi_pkg.sv]
// ----------------------------------------------------------------------------
// pswi_pkg
// shared widths, register indexes and control types of the windowed pid unit
// ----------------------------------------------------------------------------
package pswi_pkg;

   localparam int TGT_W     = 16;
   localparam int ERR_W     = 18;
   localparam int SUM_W     = 24;
   localparam int COEF_W    = 32;
   localparam int DRIVE_W   = 32;
   localparam int FRAC_W    = 16;
   localparam int INNER_W   = 58;
   localparam int LO_W      = 29;
   localparam int PROD_W    = COEF_W + INNER_W;
   localparam int Q_W       = PROD_W - 32;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

   localparam logic signed [COEF_W-1:0] PROP_GAIN_RESET = 32'sd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN        = 2'd0,
      CSR_INTEGRAL_COEFF   = 2'd1,
      CSR_DERIVATIVE_COEFF = 2'd2,
      CSR_POLARITY_DIRECT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic load_in;
      logic calc_err;
      logic upd_ring;
      logic mul_terms;
      logic add_inner;
      logic mul_gain;
      logic sum_prod;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage

[rtl/pswi_ctrl.sv]
// ----------------------------------------------------------------------------
// pswi_ctrl
// step sequencer: walks one item through the datapath steps
// ----------------------------------------------------------------------------
module pswi_ctrl
   import pswi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_UPD,
      ST_MULT,
      ST_ADD,
      ST_GAIN,
      ST_PROD,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_in = req_valid;
            if (req_valid) state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.calc_err = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd_ring = 1'b1;
            state_in     = ST_MULT;
         end
         ST_MULT: begin
            cmd.mul_terms = 1'b1;
            state_in      = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_inner = 1'b1;
            state_in      = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.mul_gain = 1'b1;
            state_in     = ST_PROD;
         end
         ST_PROD: begin
            cmd.sum_prod = 1'b1;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/pswi_datapath.sv]
// ----------------------------------------------------------------------------
// pswi_datapath
// error ring, running sum, coefficient products and output saturation
// ----------------------------------------------------------------------------
module pswi_datapath
   import pswi_pkg::*;
#(
   parameter int WINDOW = 20
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic signed [TGT_W-1:0]   req_target,
   input  logic signed [TGT_W-1:0]   req_measurement,
   input  logic                      csr_valid,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [COEF_W-1:0]         csr_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [DRIVE_W-1:0] rsp_drive,
   output logic                      rsp_saturated
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(DRIVE_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(DRIVE_MIN);
   localparam logic [PROD_W-1:0] TRUNC_BIAS = {{(PROD_W-32){1'b0}}, {32{1'b1}}};

   // configuration
   logic signed [COEF_W-1:0] kp_ff, ic_ff, dc_ff;
   logic                     pol_ff;

   // ring state
   logic signed [ERR_W-1:0]  ring_mem [WINDOW];
   logic signed [ERR_W-1:0]  old_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [FILL_W-1:0]        fill_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic signed [ERR_W-1:0]  last_ff;
   logic                     full;

   // working registers
   logic signed [TGT_W-1:0]          tgt_ff, meas_ff;
   logic signed [ERR_W-1:0]          err_ff, err_in, meas_ext;
   logic signed [ERR_W:0]            diff_ff;
   logic signed [COEF_W+SUM_W-1:0]   prod_i_ff;
   logic signed [COEF_W+ERR_W:0]     prod_d_ff;
   logic signed [INNER_W-1:0]        inner_ff, inner_in;
   logic signed [COEF_W+LO_W:0]      p_lo_ff;
   logic signed [COEF_W+INNER_W-LO_W-1:0] p_hi_ff;
   logic signed [PROD_W-1:0]         full_ff, full_in;
   logic [PROD_W-1:0]                biased;
   logic signed [Q_W-1:0]            quot;

   // output register
   logic                      rsp_valid_ff;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;
   logic                      sat_ff, sat_in;

   assign full = (fill_ff == FILL_FULL);

   always_comb begin
      meas_ext = pol_ff ? ERR_W'(meas_ff) : -ERR_W'(meas_ff);
      err_in   = ERR_W'(tgt_ff) - meas_ext;
   end

   always_comb begin
      sum_in = sum_ff + SUM_W'(err_ff);
      if (full) sum_in = sum_in - SUM_W'(old_ff);
   end

   assign inner_in = (INNER_W'(err_ff) <<< FRAC_W) + INNER_W'(prod_i_ff)
                   + INNER_W'(prod_d_ff);

   assign full_in = (PROD_W'(p_hi_ff) <<< LO_W) + PROD_W'(p_lo_ff);

   // truncation toward zero on the drop of the low 32 bits
   always_comb begin
      biased = full_ff[PROD_W-1] ? (full_ff + TRUNC_BIAS) : full_ff;
      quot   = $signed(biased[PROD_W-1:32]);
      sat_in = 1'b0;
      if (quot > Q_MAX) begin
         drive_in = DRIVE_MAX;
         sat_in   = 1'b1;
      end else if (quot < Q_MIN) begin
         drive_in = DRIVE_MIN;
         sat_in   = 1'b1;
      end else begin
         drive_in = quot[DRIVE_W-1:0];
      end
   end

   // error ring memory
   always_ff @(posedge clock) begin
      if (cmd.calc_err) old_ff <= ring_mem[slot_ff];
      if (cmd.upd_ring) ring_mem[slot_ff] <= err_ff;
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= PROP_GAIN_RESET;
         ic_ff        <= '0;
         dc_ff        <= '0;
         pol_ff       <= 1'b1;
         sum_ff       <= '0;
         fill_ff      <= '0;
         slot_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_PROP_GAIN:        kp_ff  <= $signed(csr_data);
               CSR_INTEGRAL_COEFF:   ic_ff  <= $signed(csr_data);
               CSR_DERIVATIVE_COEFF: dc_ff  <= $signed(csr_data);
               CSR_POLARITY_DIRECT:  pol_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.upd_ring) begin
            sum_ff  <= sum_in;
            last_ff <= err_ff;
            if (!full) fill_ff <= fill_ff + 1'b1;
            slot_ff <= (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
         end
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         tgt_ff  <= req_target;
         meas_ff <= req_measurement;
      end
      if (cmd.calc_err) err_ff <= err_in;
      if (cmd.upd_ring) diff_ff <= (ERR_W+1)'(err_ff) - (ERR_W+1)'(last_ff);
      if (cmd.mul_terms) begin
         prod_i_ff <= ic_ff * sum_ff;
         prod_d_ff <= dc_ff * diff_ff;
      end
      if (cmd.add_inner) inner_ff <= inner_in;
      if (cmd.mul_gain) begin
         p_lo_ff <= kp_ff * $signed({1'b0, inner_ff[LO_W-1:0]});
         p_hi_ff <= kp_ff * $signed(inner_ff[INNER_W-1:LO_W]);
      end
      if (cmd.sum_prod) full_ff <= full_in;
      if (cmd.load_out) begin
         drive_ff <= drive_in;
         sat_ff   <= sat_in;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive       = drive_ff;
   assign rsp_saturated   = sat_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fill count beyond window depth");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_LAST)
      else $error("write slot beyond window depth");

   a_slot_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      !full |-> (FILL_W'(slot_ff) == fill_ff))
      else $error("write slot and fill count disagree before ring is full");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |-> (drive_ff == DRIVE_MAX || drive_ff == DRIVE_MIN))
      else $error("saturated flag without clipped drive");

   a_ring_step: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_ring |=> (last_ff == $past(err_ff)))
      else $error("previous error not taken from ring update");
`endif

endmodule

[rtl/pid_sliding_window_integral_unit.sv]
// ----------------------------------------------------------------------------
// pid_sliding_window_integral_unit
// pid controller with an integral term over a sliding window of errors
// ----------------------------------------------------------------------------
// each item carries a setpoint and a measurement; the unit forms the error
// (measurement negated when polarity_direct is 0), keeps the last WINDOW
// errors in a ring with a running sum and returns
// drive = kp * (error + icoef*sum + dcoef*(error - previous error)), kept
// exact internally, truncated toward zero and clipped to 32-bit signed with
// a saturated flag. one item is worked at a time: the next item is taken
// only after the result of the last one is loaded into the output register
// and the sequencer is back in idle. the step sequencer walks the item
// through error forming, ring update, the coefficient multipliers, the inner
// sum, the split 32 by 58 bit gain multiply, the partial product sum and the
// final rounding and clip. a pending result holds the sequencer in its last
// step with req_ready low until the output register frees up, which
// stretches the item by the cycles of that stall. coefficients are to be
// written through the csr port while the unit is idle; the unit itself does
// not enforce this. no clearing pass is needed after reset
// ----------------------------------------------------------------------------
module pid_sliding_window_integral_unit
   import pswi_pkg::*;
#(
   parameter int WINDOW = 20
)
(
   input  logic                      clock,
   input  logic                      reset,
   // input items
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [TGT_W-1:0]   req_target,
   input  logic signed [TGT_W-1:0]   req_measurement,
   // result items
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DRIVE_W-1:0] rsp_drive,
   output logic                      rsp_saturated,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [COEF_W-1:0]         csr_data
);

   cmd_type    cmd;
   status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencer
   pswi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, ring and output register
   pswi_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_target      (req_target),
      .req_measurement (req_measurement),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_drive       (rsp_drive),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

[tb/pswi_drive_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pswi_drive_checker
// watches the item, result and register channels of the windowed pid unit,
// works out the drive of every accepted item and compares it with the
// results in order
// ----------------------------------------------------------------------------
module pswi_drive_checker
   import pswi_pkg::*;
#(
   parameter int WINDOW = 20
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [TGT_W-1:0]   req_target,
   input  logic signed [TGT_W-1:0]   req_measurement,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [DRIVE_W-1:0] rsp_drive,
   input  logic                      rsp_saturated,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [COEF_W-1:0]         csr_data,
   output int                        mismatches,
   output int                        pending
);

   typedef struct {
      logic signed [DRIVE_W-1:0] drive;
      logic                      saturated;
   } drive_result_type;

   drive_result_type expected_drives[$];
   drive_result_type oldest;

   // controller state
   logic signed [ERR_W-1:0]  error_ring [WINDOW];
   logic signed [SUM_W-1:0]  error_sum;
   int unsigned              ring_fill;
   int unsigned              ring_slot;
   logic signed [ERR_W-1:0]  prev_error;

   // coefficient registers
   logic signed [COEF_W-1:0] kp;
   logic signed [COEF_W-1:0] icoef;
   logic signed [COEF_W-1:0] dcoef;
   logic                     direct_polarity;

   function automatic drive_result_type predict_drive(
                                          input logic signed [TGT_W-1:0] target,
                                          input logic signed [TGT_W-1:0] measurement);
      logic signed [ERR_W-1:0] meas_x;
      logic signed [ERR_W-1:0] err_now;
      logic signed [ERR_W:0]   err_step;
      logic signed [63:0]      inner;
      logic [63:0]             gain_mag;
      logic [63:0]             inner_mag;
      logic [127:0]            quot;
      logic                    neg;
      drive_result_type        res;
      meas_x = ERR_W'(measurement);
      if (!direct_polarity)
         meas_x = -meas_x;
      err_now = ERR_W'(target) - meas_x;

      // ring with running sum, oldest error drops out once full
      if (ring_fill >= WINDOW)
         error_sum = error_sum - error_ring[ring_slot];
      else
         ring_fill++;
      error_ring[ring_slot] = err_now;
      error_sum = error_sum + err_now;
      ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;

      err_step = err_now - prev_error;
      inner = longint'(err_now) * 65536 + longint'(icoef) * longint'(error_sum)
            + longint'(dcoef) * longint'(err_step);
      prev_error = err_now;

      // exact Q.32 product, truncated toward zero
      neg = (kp < 0) != (inner < 0);
      gain_mag = (kp < 0) ? -longint'(kp) : longint'(kp);
      inner_mag = (inner < 0) ? -inner : inner;
      quot = gain_mag * inner_mag;
      quot = quot >> 32;

      res.saturated = 1'b0;
      if (neg) begin
         if (quot > 128'h8000_0000) begin
            quot = 128'h8000_0000;
            res.saturated = 1'b1;
         end
         res.drive = -quot[31:0];
      end else begin
         if (quot > 128'h7FFF_FFFF) begin
            quot = 128'h7FFF_FFFF;
            res.saturated = 1'b1;
         end
         res.drive = quot[31:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_drives.delete();
         error_sum = '0;
         ring_fill = 0;
         ring_slot = 0;
         prev_error = '0;
         kp = PROP_GAIN_RESET;
         icoef = '0;
         dcoef = '0;
         direct_polarity = 1'b1;
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PROP_GAIN:        kp = csr_data;
               CSR_INTEGRAL_COEFF:   icoef = csr_data;
               CSR_DERIVATIVE_COEFF: dcoef = csr_data;
               CSR_POLARITY_DIRECT:  direct_polarity = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_drives.push_back(predict_drive(req_target, req_measurement));
         if (rsp_valid && rsp_ready) begin
            if (expected_drives.size() == 0) begin
               $error("drive: expected no result, got %0d", rsp_drive);
               mismatches++;
            end else begin
               oldest = expected_drives.pop_front();
               if (rsp_drive !== oldest.drive) begin
                  $error("drive: expected %0d, got %0d", oldest.drive, rsp_drive);
                  mismatches++;
               end
               if (rsp_saturated !== oldest.saturated) begin
                  $error("saturated: expected %0d, got %0d", oldest.saturated,
                         rsp_saturated);
                  mismatches++;
               end
            end
         end
      end
      pending = expected_drives.size();
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// item and register stimulus for the windowed pid unit
// ----------------------------------------------------------------------------
// a directed part walks the input extremes through the reset coefficients,
// saturating gains of both signs, inverted polarity and a zero gain; then
// random phases each load a fresh coefficient set (full range, extremes or
// plant-like values) and send a run of items, mostly small errors so that
// the windowed sum stays meaningful, with some full-range items mixed in.
// the checker beside the unit predicts and compares every result; this
// module only drives the channels, throttles both sides and gives the verdict
// ----------------------------------------------------------------------------
module tb;
   import pswi_pkg::*;

   localparam int WINDOW_DEPTH    = 20;
   localparam int RESET_CYCLES    = 12;
   localparam int IDLE_LIMIT      = 2000;   // far above gap + latency + stall
   localparam int SETTLE_CYCLES   = 16;     // quiet time before the verdict
   localparam int RANDOM_PHASES   = 9;
   localparam int ITEMS_PER_PHASE = 50;

   localparam logic signed [TGT_W-1:0] TGT_MAX = 16'sh7FFF;
   localparam logic signed [TGT_W-1:0] TGT_MIN = 16'sh8000;
   localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
   localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;
   localparam logic [COEF_W-1:0] UNITY    = 32'h0001_0000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [TGT_W-1:0]   req_target = '0;
   logic signed [TGT_W-1:0]   req_measurement = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive;
   logic                      rsp_saturated;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_PROP_GAIN;
   logic [COEF_W-1:0]         csr_data = '0;

   int          mismatches;
   int          pending;
   bit          steady_flow = 1'b0;   // no idling on either side while set
   int unsigned result_hold = 0;
   int unsigned stall_draw;
   int unsigned idle_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pid_sliding_window_integral_unit #(
      .WINDOW (WINDOW_DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_target      (req_target),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive       (rsp_drive),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   pswi_drive_checker #(
      .WINDOW (WINDOW_DEPTH)
   ) drive_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_target      (req_target),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive       (rsp_drive),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .pending         (pending)
   );

   // result side: after each accepted result ready drops for a drawn number of
   // cycles, counted only while a result is waiting so the stall really bites
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         result_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         stall_draw = steady_flow ? 0 : $urandom_range(0, 9);
         result_hold <= stall_draw;
         if (stall_draw > 0)
            rsp_ready <= 1'b0;
      end else if (result_hold > 0) begin
         if (rsp_valid) begin
            result_hold <= result_hold - 1;
            if (result_hold == 1)
               rsp_ready <= 1'b1;
         end
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog: too long with no handshake on any channel means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // valid stays high from one item to the next when no gap is drawn, so
   // it is never lowered and raised in the same step
   task automatic send_item(input logic signed [TGT_W-1:0] target,
                            input logic signed [TGT_W-1:0] measurement);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target <= target;
      req_measurement <= measurement;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drops valid and lets the checker book the last accepted item before waiting on pending
   task automatic wait_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_word(input csr_index_type idx, input logic [COEF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // coefficients only change with the unit drained
   task automatic set_controller(input logic [COEF_W-1:0] gain,
                                 input logic [COEF_W-1:0] icoef,
                                 input logic [COEF_W-1:0] dcoef,
                                 input logic [COEF_W-1:0] polarity_word);
      wait_results();
      write_word(CSR_PROP_GAIN, gain);
      write_word(CSR_INTEGRAL_COEFF, icoef);
      write_word(CSR_DERIVATIVE_COEFF, dcoef);
      write_word(CSR_POLARITY_DIRECT, polarity_word);
      csr_valid <= 1'b0;
   endtask

   // full range, extremes, or a value within +-span
   function automatic logic [COEF_W-1:0] pick_coef(input int unsigned style,
                                                   input int unsigned span);
      int v;
      case (style)
         0: return $urandom();
         1: begin
            case ($urandom_range(0, 4))
               0: return COEF_MAX;
               1: return COEF_MIN;
               2: return '0;
               3: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: begin
            v = int'($urandom_range(0, 2 * span)) - int'(span);
            return v;
         end
      endcase
   endfunction

   // small errors keep the window sum in a plant-like range
   function automatic logic signed [TGT_W-1:0] near_zero();
      return TGT_W'(int'($urandom_range(0, 4000)) - 2000);
   endfunction

   initial begin
      int unsigned style;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: unity gain, drive equals the error
      send_item(16'sd0, 16'sd0);
      send_item(TGT_MAX, TGT_MIN);
      send_item(TGT_MIN, TGT_MAX);
      send_item(TGT_MIN, TGT_MIN);
      send_item(TGT_MAX, TGT_MAX);
      send_item(-16'sd1, 16'sd0);
      send_item(16'sd0, -16'sd1);

      // largest gains, inverted polarity with upper data bits set: clips high
      // and low, and the most negative error
      set_controller(COEF_MAX, COEF_MAX, COEF_MIN, 32'hFFFF_FFFE);
      send_item(TGT_MAX, TGT_MAX);
      send_item(TGT_MIN, TGT_MIN);
      send_item(TGT_MAX, TGT_MIN);
      send_item(16'sd0, 16'sd0);
      send_item(TGT_MIN, TGT_MIN);

      // most negative gain flips the sign of a large inner term
      set_controller(COEF_MIN, '0, COEF_MAX, 32'hFFFF_FFFF);
      send_item(TGT_MAX, TGT_MIN);
      send_item(TGT_MIN, TGT_MAX);
      send_item(16'sd0, 16'sd0);
      send_item(16'sd100, -16'sd100);

      // zero gain, then a small plant-like set
      set_controller('0, COEF_MAX, COEF_MAX, 32'h0000_0001);
      send_item(TGT_MAX, TGT_MIN);
      send_item(TGT_MIN, TGT_MAX);
      set_controller(UNITY, 32'h0000_0CCD, 32'hFFFF_0000, 32'h0000_0000);
      send_item(16'sd1000, 16'sd200);
      send_item(16'sd1000, 16'sd900);
      send_item(-16'sd500, 16'sd20);
      send_item(16'sd3, -16'sd7);

      // random phases, each with its own coefficients and flow pattern
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         style = $urandom_range(0, 3);
         set_controller(pick_coef(style, 1 << 18), pick_coef(style, 1 << 14),
                        pick_coef(style, 1 << 17), $urandom());
         steady_flow = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) < 7)
               send_item(near_zero(), near_zero());
            else
               send_item(TGT_W'($urandom()), TGT_W'($urandom()));
         end
         steady_flow = 1'b0;
      end

      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

[sim.f]
rtl/pswi_pkg.sv
rtl/pswi_ctrl.sv
rtl/pswi_datapath.sv
rtl/pid_sliding_window_integral_unit.sv
tb/pswi_drive_checker.sv
tb/tb.sv
